// ===== design/xcfc_pkg.sv =====
`default_nettype none

package xcfc_pkg;

   localparam int MAX_FRAME_DEF = 64;

   // Frame layout constants.
   localparam int SHORT_LIMIT   = 5;
   localparam int XOR_START     = 2;
   localparam int PAYLOAD_START = 4;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_BADSUM   = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } frame_status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0]       payload_byte;
      frame_status_type frame_status;
      logic             run_last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } ctrl_state_type;

   typedef struct packed {
      logic store;
      logic emit_status;
      logic load_ptr;
      logic read;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      frame_status_type verdict;
      logic             last_addr;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== design/xcfc_ram.sv =====
`default_nettype none

module xcfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/xcfc_ctrl.sv =====
`default_nettype none

module xcfc_ctrl
   import xcfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic        frame_end,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd,
   output logic             busy
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!frame_end) begin
                  cmd.store = 1'b1;
               end else if (stat.verdict != STATUS_OK) begin
                  cmd.emit_status = 1'b1;
                  cmd.clear       = 1'b1;
               end else begin
                  cmd.load_ptr = 1'b1;
                  state_in     = ST_READ;
               end
            end
         end
         ST_READ: begin
            busy     = 1'b1;
            cmd.read = 1'b1;
            if (stat.last_addr) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/xcfc_datapath.sv =====
`default_nettype none

module xcfc_datapath
   import xcfc_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   input  wire dp_cmd_type cmd,
   output dp_stat_type     stat,
   output logic            rsp_strobe,
   output rsp_type         rsp_data
);

   localparam int CountWidth = $clog2(MAX_FRAME + 1);
   localparam int AddrWidth  = $clog2(MAX_FRAME);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            xor_ff, xor_in;
   logic                  ovf_ff, ovf_in;
   logic [AddrWidth-1:0]  ptr_ff, ptr_in;

   logic                  valid_ff, valid_in;
   frame_status_type      status_ff, status_in;
   logic                  last_ff, last_in;
   logic                  sel_ram_ff, sel_ram_in;

   logic                  room;
   logic                  wr_en;
   logic [7:0]            rd_data;
   frame_status_type      verdict;
   logic                  last_addr;

   assign room = count_ff < CountWidth'(MAX_FRAME);
   assign wr_en = cmd.store && room;

   // Judge the frame for overflow and shortness, and against the closing byte, which is the received checksum.
   always_comb begin
      priority if (ovf_ff || !room) begin
         verdict = STATUS_OVERFLOW;
      end else if (count_ff < CountWidth'(SHORT_LIMIT)) begin
         verdict = STATUS_SHORT;
      end else if (xor_ff != req_data.rx_byte) begin
         verdict = STATUS_BADSUM;
      end else begin
         verdict = STATUS_OK;
      end
   end

   // The last payload byte sits just before the checksum, at count minus one.
   assign last_addr = (CountWidth'(ptr_ff) + CountWidth'(1)) == count_ff;

   assign stat = '{verdict: verdict, last_addr: last_addr};

   always_comb begin
      count_in = count_ff;
      xor_in   = xor_ff;
      ovf_in   = ovf_ff;
      ptr_in   = ptr_ff;
      if (cmd.store) begin
         if (room) begin
            count_in = count_ff + CountWidth'(1);
            if (count_ff >= CountWidth'(XOR_START)) begin
               xor_in = xor_ff ^ req_data.rx_byte;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.load_ptr) begin
         ptr_in = AddrWidth'(PAYLOAD_START);
      end else if (cmd.read) begin
         ptr_in = ptr_ff + AddrWidth'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
         xor_in   = '0;
         ovf_in   = 1'b0;
      end
   end

   always_comb begin
      valid_in   = 1'b0;
      status_in  = status_ff;
      last_in    = last_ff;
      sel_ram_in = sel_ram_ff;
      if (cmd.emit_status) begin
         valid_in   = 1'b1;
         status_in  = verdict;
         last_in    = 1'b1;
         sel_ram_in = 1'b0;
      end else if (cmd.read) begin
         valid_in   = 1'b1;
         status_in  = STATUS_OK;
         last_in    = last_addr;
         sel_ram_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         xor_ff   <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         xor_ff   <= xor_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      status_ff  <= status_in;
      last_ff    <= last_in;
      sel_ram_ff <= sel_ram_in;
   end

   xcfc_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrWidth-1:0]),
      .wr_data (req_data.rx_byte),
      .rd_en   (cmd.read),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign rsp_strobe = valid_ff;
   assign rsp_data   = '{payload_byte: (sel_ram_ff ? rd_data : 8'd0),
                         frame_status: status_ff,
                         run_last:     last_ff};

endmodule

`default_nettype wire

// ===== design/xor_checksum_frame_checker.sv =====
// Frame checker for a serial link with an XOR checksum.
// Request channel: a byte is taken at a rising edge where start is high and
// busy is low; req_data.frame_end marks the checksum byte that closes a frame.
// Bytes before the closing one are written into a MAX_FRAME-entry buffer RAM,
// one per cycle while it has room, else overflow is flagged; they never raise busy.
// Response channel: each result is held on rsp_data for exactly one cycle
// while rsp_strobe is high. The receiver has no way to stall it.
// A closing byte on a short, overflowed or bad-checksum frame yields one status
// result in the next cycle, and the next request may be taken at once.
// On a good frame, busy is high in the read state while the payload is read
// back one byte per cycle through the registered RAM port; each payload
// result appears in the cycle after its read, the first one after the
// pointer load and first read, and the last one carries run_last.
// The next request may be taken in the cycle the last payload byte is shown.
// Synchronous reset clears the byte count, checksum and overflow flag and
// returns the controller to idle; the buffer itself is not cleared.
`default_nettype none

module xor_checksum_frame_checker
   import xcfc_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        accept;

   assign accept = start && !busy;

   xcfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .frame_end (req_data.frame_end),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   xcfc_datapath #(
      .MAX_FRAME (MAX_FRAME)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/sv/xor_checksum_frame_checker_tb.sv =====
`default_nettype none

module xor_checksum_frame_checker_tb;
   import xcfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_DEPTH = MAX_FRAME_DEF;
   localparam int RANDOM_BYTES = 345;

   // Tracks the frame being received and the results each closing byte must produce.
   class frame_tracker;
      logic [7:0] frame_buf [FRAME_DEPTH];
      int unsigned fill;
      logic [7:0] sum_acc;
      bit dropped;
      rsp_type frame_results_q [$];
      int unsigned mismatches;
      int unsigned bytes_taken;
      int unsigned results_seen;
      int unsigned status_seen [4];

      function new();
         fill = 0;
         sum_acc = '0;
         dropped = 1'b0;
         mismatches = 0;
         bytes_taken = 0;
         results_seen = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void push_result(logic [7:0] pay, frame_status_type st, logic last);
         rsp_type r;
         r.payload_byte = pay;
         r.frame_status = st;
         r.run_last = last;
         frame_results_q.push_back(r);
      endfunction

      function void take_byte(req_type r);
         int unsigned len;
         bytes_taken++;
         if (!r.frame_end) begin
            if (fill < FRAME_DEPTH) begin
               frame_buf[fill] = r.rx_byte;
               if (fill >= XOR_START) sum_acc ^= r.rx_byte;
               fill++;
            end else begin
               dropped = 1'b1;
            end
            return;
         end
         // The closing byte is the checksum, so the frame is one byte longer than the store.
         len = fill + 1;
         if (dropped || len > FRAME_DEPTH) begin
            push_result(8'h00, STATUS_OVERFLOW, 1'b1);
         end else if (len <= SHORT_LIMIT) begin
            push_result(8'h00, STATUS_SHORT, 1'b1);
         end else if (sum_acc != r.rx_byte) begin
            push_result(8'h00, STATUS_BADSUM, 1'b1);
         end else begin
            for (int unsigned i = PAYLOAD_START; i + 1 < len; i++)
               push_result(frame_buf[i], STATUS_OK, (i + 2 == len));
         end
         fill = 0;
         sum_acc = '0;
         dropped = 1'b0;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (frame_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response payload %02h status %0d last %0d",
                        $realtime, got.payload_byte, got.frame_status, got.run_last);
            return;
         end
         want = frame_results_q.pop_front();
         if (got.run_last === 1'b1) status_seen[want.frame_status]++;
         if (got.payload_byte !== want.payload_byte || got.frame_status !== want.frame_status
             || got.run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response payload %02h status %0d last %0d, wanted %02h %0d %0d",
                        $realtime, got.payload_byte, got.frame_status, got.run_last,
                        want.payload_byte, want.frame_status, want.run_last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;

   frame_tracker tracker = new();
   logic [7:0] frame_q [$];
   int unsigned idle_pct;
   int unsigned random_sent;

   xor_checksum_frame_checker u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) tracker.take_byte(req_data);
         if (rsp_strobe) tracker.check_result(rsp_data);
      end
   end

   // Busy is steady between rising edges, so its value at a falling edge decides the next one.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data.rx_byte = b;
      req_data.frame_end = last;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) begin
         send_byte(frame_q[i], i == frame_q.size() - 1);
         random_sent++;
      end
   endtask

   // Random bytes followed by a checksum byte that is either right or off by a nonzero mask.
   task automatic build_frame(input int unsigned len, input bit good_sum);
      logic [7:0] b;
      logic [7:0] acc;
      acc = '0;
      frame_q.delete();
      for (int unsigned i = 0; i + 1 < len; i++) begin
         b = 8'($urandom);
         frame_q.push_back(b);
         if (i >= XOR_START) acc ^= b;
      end
      if (good_sum) frame_q.push_back(acc);
      else frame_q.push_back(acc ^ 8'($urandom_range(1, 255)));
   endtask

   initial begin
      int unsigned idle_phase_pct [4];
      int unsigned frame_idx;
      int unsigned pick;
      int unsigned guard;
      idle_phase_pct = '{0, 67, 0, 9};
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_pct = 0;
      random_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: single-byte frame, five-byte frame at the short limit, smallest good frame,
      // the same frame with a bad checksum, and a good frame carrying payload bytes 00 and 80.
      frame_q = '{8'h00};
      send_frame();
      frame_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
      send_frame();
      frame_q = '{8'h00, 8'hff, 8'h06, 8'h00, 8'hff, 8'hf9};
      send_frame();
      frame_q = '{8'h00, 8'hff, 8'h06, 8'h00, 8'hff, 8'hf8};
      send_frame();
      frame_q = '{8'haa, 8'h55, 8'h07, 8'hff, 8'h00, 8'h80, 8'h07 ^ 8'hff ^ 8'h80};
      send_frame();

      random_sent = 0;
      frame_idx = 0;
      while (random_sent < RANDOM_BYTES) begin
         idle_pct = idle_phase_pct[(random_sent * 4) / RANDOM_BYTES];
         pick = $urandom_range(99);
         // A full-size good frame, one just past the buffer, and one far past it.
         if (frame_idx == 4) build_frame(FRAME_DEPTH, 1'b1);
         else if (frame_idx == 9) build_frame(FRAME_DEPTH + 1, 1'b1);
         else if (frame_idx == 14) build_frame($urandom_range(FRAME_DEPTH + 2, 90), 1'b1);
         else if (pick < 70)
            build_frame(($urandom_range(9) == 0) ? $urandom_range(17, FRAME_DEPTH - 1)
                                                 : $urandom_range(6, 16), 1'b1);
         else if (pick < 80) build_frame($urandom_range(6, 16), 1'b0);
         else if (pick < 88) build_frame($urandom_range(1, SHORT_LIMIT), 1'($urandom_range(1)));
         else begin
            frame_q.delete();
            repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom));
         end
         send_frame();
         frame_idx++;
      end

      @(negedge clock);
      start = 1'b0;
      guard = 0;
      while (tracker.frame_results_q.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d request bytes in %0d frames, checked %0d responses.",
               tracker.bytes_taken, frame_idx + 5, tracker.results_seen);
      $display("Frames closed: %0d ok, %0d short, %0d bad checksum, %0d overflow; %0d left.",
               tracker.status_seen[STATUS_OK], tracker.status_seen[STATUS_SHORT],
               tracker.status_seen[STATUS_BADSUM], tracker.status_seen[STATUS_OVERFLOW],
               tracker.frame_results_q.size());
      if (tracker.mismatches == 0 && tracker.frame_results_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
design/xcfc_pkg.sv
design/xcfc_ram.sv
design/xcfc_ctrl.sv
design/xcfc_datapath.sv
design/xor_checksum_frame_checker.sv
tb/sv/xor_checksum_frame_checker_tb.sv
